### sv/lzwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

	localparam int WIN_DEPTH    = 4096;
	localparam int SHORT_DEPTH  = 512;
	localparam int ADDR_W       = 12;
	localparam int LONG_MAXLEN  = 18;
	localparam int SHORT_MAXLEN = 130;
	localparam int MIN_MATCH    = 3;
	localparam int LEN_W        = 8;
	localparam int EPOCH_W      = 4;
	localparam int CFG_IDX_W    = 4;
	localparam int COUNT_W      = 3;
	localparam int OUT_PORTS    = 4;

	typedef logic [7:0]           data_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [EPOCH_W-1:0]   epoch_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [COUNT_W-1:0]   count_t;

	localparam cfg_idx_t REG_WINDOW_MODE   = cfg_idx_t'(0);
	localparam cfg_idx_t REG_OUTPUT_LENGTH = cfg_idx_t'(1);

	localparam addr_t LONG_MASK  = addr_t'(WIN_DEPTH - 1);
	localparam addr_t SHORT_MASK = addr_t'(SHORT_DEPTH - 1);
	localparam addr_t LONG_START  = addr_t'(WIN_DEPTH - LONG_MAXLEN);
	localparam addr_t SHORT_START = addr_t'(SHORT_DEPTH - SHORT_MAXLEN);

	typedef enum logic [1:0] {
		PH_FLAG  = 2'd0,
		PH_TOKEN = 2'd1,
		PH_HIGH  = 2'd2,
		PH_SPARE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_INPUT = 3'b010,
		ST_MATCH = 3'b100
	} state_t;

	typedef struct packed {
		epoch_t tag;
		data_t  value;
	} entry_t;

	typedef struct packed {
		logic   we;
		addr_t  waddr;
		entry_t wdata;
		logic   re;
		addr_t  raddr;
	} mem_req_t;

	typedef struct packed {
		data_t value;
		logic  last;
		logic  fin;
	} pk_req_t;

endpackage

`default_nettype wire

### sv/lzwd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lzwd_in_if;
	logic            valid;
	logic            ready;
	lzwd_pkg::data_t in_byte;
	logic            stream_start;

	modport source (output valid, output in_byte, output stream_start, input ready);
	modport sink (input valid, input in_byte, input stream_start, output ready);
endinterface

interface lzwd_out_if;
	logic               valid;
	logic               ready;
	lzwd_pkg::data_t    out_byte0;
	lzwd_pkg::data_t    out_byte1;
	lzwd_pkg::data_t    out_byte2;
	lzwd_pkg::data_t    out_byte3;
	lzwd_pkg::count_t   byte_count;
	logic               run_end;
	logic               stream_end;

	modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
		output out_byte3, output byte_count, output run_end, output stream_end, input ready);
	modport sink (input valid, input out_byte0, input out_byte1, input out_byte2,
		input out_byte3, input byte_count, input run_end, input stream_end, output ready);
endinterface

interface lzwd_cfg_if;
	logic               valid;
	logic               ready;
	lzwd_pkg::cfg_idx_t index;
	logic [31:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/lzwd_window_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lzwd_window_mem (
	input  wire logic               clk,
	input  wire lzwd_pkg::mem_req_t req,
	output      lzwd_pkg::entry_t   rdata
);
	import lzwd_pkg::*;

	entry_t mem_q [WIN_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

`default_nettype wire

### sv/lzwd_packer.sv
`timescale 1ns / 1ps
`default_nettype none

module lzwd_packer #(
	parameter int OUT_LANES = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire lzwd_pkg::pk_req_t req,
	output      logic              req_ready,
	lzwd_out_if.source             out_ch
);
	import lzwd_pkg::*;

	localparam int LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > OUT_PORTS) ? OUT_PORTS : OUT_LANES);
	localparam count_t LAST_LANE = count_t'(LANES - 1);

	data_t  lane_q [LANES];
	count_t cnt_q;
	data_t  lane_val [OUT_PORTS];
	data_t  ob_q [OUT_PORTS];
	logic   out_valid_q;
	count_t out_count_q;
	logic   run_end_q;
	logic   stream_end_q;
	logic   flush;
	logic   out_free;
	logic   acc;

	assign flush     = req.last || (cnt_q == LAST_LANE);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign req_ready = !flush || out_free;
	assign acc       = req_valid && req_ready;

	// compose a result from the collected lanes plus the arriving byte
	for (genvar g = 0; g < OUT_PORTS; g++) begin : g_lane
		if (g < LANES) begin : g_used
			assign lane_val[g] = (cnt_q > count_t'(g)) ? lane_q[g] :
				((cnt_q == count_t'(g)) ? req.value : '0);
		end else begin : g_unused
			assign lane_val[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q <= flush ? '0 : count_t'(cnt_q + 1'b1);
			end
			if (acc && flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (acc && !flush && (cnt_q == count_t'(i))) begin
				lane_q[i] <= req.value;
			end
		end
		if (acc && flush) begin
			ob_q         <= lane_val;
			out_count_q  <= count_t'(cnt_q + 1'b1);
			run_end_q    <= req.last;
			stream_end_q <= req.fin;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_byte0  = ob_q[0];
	assign out_ch.out_byte1  = ob_q[1];
	assign out_ch.out_byte2  = ob_q[2];
	assign out_ch.out_byte3  = ob_q[3];
	assign out_ch.byte_count = out_count_q;
	assign out_ch.run_end    = run_end_q;
	assign out_ch.stream_end = stream_end_q;

endmodule

`default_nettype wire

### sv/lzwd_window_decompressor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// LZSS decompressor for LZ08/LZ12 style streams, fed one compressed byte per request
// on in_ch, header already removed. stream_start on the first byte of a stream
// starts a fresh window and loads the byte count from the output_length register.
// The user must write the registers on cfg (index 0 window_mode, index 1 output_length)
// only while the block is idle; the block itself does not enforce this. cfg is always ready.
// Decoded bytes leave on out_ch packed up to four per request, with run_end on the
// last request caused by an input byte and stream_end on the one completing the count.
// A literal passes through the write stage and the packer's output register to out_ch.
// A match is copied from the window after its high byte: the window memory gives one
// byte per cycle while the packer accepts, so a match of length L holds in_ch until
// its L bytes are copied or the byte count runs out. Copies that overlap their own
// output are forwarded from the write stage.
// After reset the window memory is swept to zero over all 4096 entries while in_ch
// is held off; the same sweep runs after every sixteenth stream start, when the
// 4-bit stream tag kept beside each window entry wraps.
// When out_ch stalls, the packer fills up and in_ch and the match copy stall with it;
// nothing is dropped.
module lzss_window_decompressor_core #(
	parameter int OUT_LANES = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lzwd_in_if.sink    in_ch,
	lzwd_out_if.source out_ch,
	lzwd_cfg_if.sink   cfg
);
	import lzwd_pkg::*;

	// configuration
	logic        mode_q;
	logic [31:0] out_len_q;

	// control state
	state_t      state_q;
	phase_t      phase_q;
	logic [8:0]  flags_q;
	data_t       low_q;
	logic [31:0] rem_q;
	addr_t       wp_q;
	addr_t       rd_q;
	len_t        left_q;
	addr_t       clr_q;
	epoch_t      epoch_q;

	// write stage
	logic        valid_s1;
	logic        fwd_s1;
	data_t       fwd_data_s1;
	addr_t       wa_s1;
	logic        last_s1;
	logic        fin_s1;

	entry_t      rdata;
	mem_req_t    mreq;
	pk_req_t     preq;
	logic        pk_ready;
	data_t       byte_s1;
	logic        s1_adv;
	logic        issue_ok;
	logic        in_acc;
	logic        is_lit;
	logic        rd_issue;
	logic        rem_one;
	addr_t       mask;
	addr_t       raddr;
	addr_t       match_off;
	len_t        match_len;
	logic [8:0]  flags_next;

	assign mask     = mode_q ? LONG_MASK : SHORT_MASK;
	assign rem_one  = (rem_q == 32'd1);
	assign raddr    = rd_q & mask;
	assign byte_s1  = fwd_s1 ? fwd_data_s1 : ((rdata.tag == epoch_q) ? rdata.value : '0);
	assign s1_adv   = valid_s1 && pk_ready;
	assign issue_ok = !valid_s1 || s1_adv;

	assign in_ch.ready = (state_q == ST_INPUT) && issue_ok;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign is_lit      = in_acc && !in_ch.stream_start && (rem_q != '0) &&
		(phase_q == PH_TOKEN) && flags_q[0];
	assign rd_issue    = (state_q == ST_MATCH) && issue_ok;

	assign cfg.ready = 1'b1;

	assign flags_next = flags_q >> 1;

	always_comb begin
		if (mode_q) begin
			match_off = {in_ch.in_byte[7:4], low_q};
			match_len = len_t'({4'b0, in_ch.in_byte[3:0]} + len_t'(MIN_MATCH));
		end else begin
			match_off = {3'b0, in_ch.in_byte[7], low_q};
			match_len = len_t'({1'b0, in_ch.in_byte[6:0]} + len_t'(MIN_MATCH));
		end
	end

	always_comb begin
		mreq          = '0;
		mreq.re       = rd_issue;
		mreq.raddr    = raddr;
		if (state_q == ST_CLEAR) begin
			mreq.we    = 1'b1;
			mreq.waddr = clr_q;
		end else begin
			mreq.we             = s1_adv;
			mreq.waddr          = wa_s1;
			mreq.wdata.tag      = epoch_q;
			mreq.wdata.value    = byte_s1;
		end
	end

	assign preq.value = byte_s1;
	assign preq.last  = last_s1;
	assign preq.fin   = fin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b1;
			out_len_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WINDOW_MODE:   mode_q    <= cfg.data[0];
				REG_OUTPUT_LENGTH: out_len_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			phase_q  <= PH_FLAG;
			flags_q  <= '0;
			low_q    <= '0;
			rem_q    <= '0;
			wp_q     <= LONG_START;
			rd_q     <= '0;
			left_q   <= '0;
			clr_q    <= '0;
			epoch_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (is_lit || rd_issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= addr_t'(clr_q + 1'b1);
					if (clr_q == LONG_MASK) begin
						state_q <= ST_INPUT;
					end
				end
				ST_INPUT: begin
					if (in_acc) begin
						if (in_ch.stream_start) begin
							// the start byte is also the first flag byte
							wp_q    <= mode_q ? LONG_START : SHORT_START;
							rem_q   <= out_len_q;
							low_q   <= '0;
							flags_q <= {1'b1, in_ch.in_byte};
							phase_q <= PH_TOKEN;
							if (epoch_q == '1) begin
								epoch_q <= '0;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_t'(epoch_q + 1'b1);
							end
						end else if (rem_q != '0) begin
							case (phase_q)
								PH_TOKEN: begin
									if (flags_q[0]) begin
										wp_q    <= (wp_q + 1'b1) & mask;
										rem_q   <= rem_q - 1'b1;
										flags_q <= flags_next;
										phase_q <= (flags_next <= 9'd1) ? PH_FLAG : PH_TOKEN;
									end else begin
										low_q   <= in_ch.in_byte;
										phase_q <= PH_HIGH;
									end
								end
								PH_HIGH: begin
									rd_q    <= match_off;
									left_q  <= match_len;
									flags_q <= flags_next;
									phase_q <= (flags_next <= 9'd1) ? PH_FLAG : PH_TOKEN;
									state_q <= ST_MATCH;
								end
								default: begin
									flags_q <= {1'b1, in_ch.in_byte};
									phase_q <= PH_TOKEN;
								end
							endcase
						end
					end
				end
				ST_MATCH: begin
					if (rd_issue) begin
						rd_q   <= addr_t'(rd_q + 1'b1);
						left_q <= len_t'(left_q - 1'b1);
						wp_q   <= (wp_q + 1'b1) & mask;
						rem_q  <= rem_q - 1'b1;
						if ((left_q == len_t'(1)) || rem_one) begin
							state_q <= ST_INPUT;
						end
					end
				end
				default: state_q <= ST_INPUT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_lit) begin
			fwd_s1      <= 1'b1;
			fwd_data_s1 <= in_ch.in_byte;
			wa_s1       <= wp_q & mask;
			last_s1     <= 1'b1;
			fin_s1      <= rem_one;
		end else if (rd_issue) begin
			// a copy reading the entry written in this same cycle takes the written byte
			fwd_s1      <= s1_adv && (raddr == wa_s1);
			fwd_data_s1 <= byte_s1;
			wa_s1       <= wp_q & mask;
			last_s1     <= (left_q == len_t'(1)) || rem_one;
			fin_s1      <= rem_one;
		end
	end

	lzwd_window_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	lzwd_packer #(
		.OUT_LANES (OUT_LANES)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (valid_s1),
		.req       (preq),
		.req_ready (pk_ready),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

### test/lzwd_stream_checker.sv
`timescale 1ns / 1ps

module lzwd_stream_checker
	import lzwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  data_t       in_byte,
	input  logic        stream_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  data_t       out_byte0,
	input  data_t       out_byte1,
	input  data_t       out_byte2,
	input  data_t       out_byte3,
	input  count_t      byte_count,
	input  logic        run_end,
	input  logic        stream_end,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [31:0] cfg_data,
	output int          words_due,
	output int          mismatches
);

	typedef struct packed {
		data_t  b0;
		data_t  b1;
		data_t  b2;
		data_t  b3;
		count_t count;
		logic   last;
		logic   done;
	} word_t;

	data_t       history [WIN_DEPTH];
	addr_t       wr_pos;
	logic [8:0]  flag_bits;
	phase_t      phase;
	data_t       match_low;
	logic [31:0] remaining;
	logic        mode_sel;
	logic [31:0] length_reg;
	data_t       produced[$];
	bit          finished;
	word_t       due_q[$];

	function automatic addr_t win_mask();
		return mode_sel ? LONG_MASK : SHORT_MASK;
	endfunction

	task automatic restart_window();
		foreach (history[i])
			history[i] = '0;
		wr_pos = mode_sel ? LONG_START : SHORT_START;
		flag_bits = '0;
		phase = PH_FLAG;
		match_low = '0;
	endtask

	task automatic emit(input data_t value);
		produced.push_back(value);
		history[wr_pos & win_mask()] = value;
		wr_pos = (wr_pos + 1'b1) & win_mask();
		remaining = remaining - 1;
		if (remaining == 0)
			finished = 1'b1;
	endtask

	task automatic next_flag();
		flag_bits = flag_bits >> 1;
		phase = (flag_bits <= 9'd1) ? PH_FLAG : PH_TOKEN;
	endtask

	task automatic decode_byte(input data_t value, input logic start);
		addr_t off;
		int    run;
		int    n;
		int    cnt;
		data_t lanes [OUT_PORTS];
		word_t w;
		produced.delete();
		finished = 1'b0;
		if (start) begin
			restart_window();
			remaining = length_reg;
		end
		if (remaining == 0)
			return;
		case (phase)
			PH_TOKEN: begin
				if (flag_bits[0]) begin
					emit(value);
					next_flag();
				end else begin
					match_low = value;
					phase = PH_HIGH;
				end
			end
			PH_HIGH: begin
				if (mode_sel) begin
					off = {value[7:4], match_low};
					run = value[3:0] + MIN_MATCH;
				end else begin
					off = {3'b000, value[7], match_low};
					run = value[6:0] + MIN_MATCH;
				end
				// copy reads see bytes written earlier in the same match
				for (int k = 0; k < run && !finished; k++)
					emit(history[(off + addr_t'(k)) & win_mask()]);
				next_flag();
			end
			default: begin
				flag_bits = {1'b1, value};
				phase = PH_TOKEN;
			end
		endcase
		n = produced.size();
		for (int base = 0; base < n; base += OUT_PORTS) begin
			cnt = (n - base > OUT_PORTS) ? OUT_PORTS : n - base;
			for (int j = 0; j < OUT_PORTS; j++)
				lanes[j] = (j < cnt) ? produced[base + j] : '0;
			w.b0 = lanes[0];
			w.b1 = lanes[1];
			w.b2 = lanes[2];
			w.b3 = lanes[3];
			w.count = count_t'(cnt);
			w.last = (base + OUT_PORTS >= n);
			w.done = finished && w.last;
			due_q.push_back(w);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			mode_sel = 1'b1;
			length_reg = '0;
			remaining = '0;
			restart_window();
			due_q.delete();
			mismatches = 0;
			words_due = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WINDOW_MODE)
					mode_sel = cfg_data[0];
				else if (cfg_index == REG_OUTPUT_LENGTH)
					length_reg = cfg_data;
			end
			if (in_valid && in_ready)
				decode_byte(in_byte, stream_start);
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					$error("decoded request with nothing expected: byte0 %0h count %0d",
						out_byte0, byte_count);
					mismatches++;
				end else begin
					w = due_q.pop_front();
					check_field("out_byte0", w.b0, out_byte0);
					check_field("out_byte1", w.b1, out_byte1);
					check_field("out_byte2", w.b2, out_byte2);
					check_field("out_byte3", w.b3, out_byte3);
					check_field("byte_count", 8'(w.count), 8'(byte_count));
					check_field("run_end", 8'(w.last), 8'(run_end));
					check_field("stream_end", 8'(w.done), 8'(stream_end));
				end
			end
			words_due = due_q.size();
		end
	end

endmodule

### test/tb_lzss_window_decompressor_core.sv
`timescale 1ns / 1ps

module tb_lzss_window_decompressor_core;
	import lzwd_pkg::*;

	logic        clk;
	logic        arst_n;
	int          gap_pct;
	int          stall_pct;
	int unsigned items;
	bit          cur_mode;
	int          words_due;
	int          mismatches;

	lzwd_in_if  in_ch ();
	lzwd_out_if out_ch ();
	lzwd_cfg_if cfg ();

	lzss_window_decompressor_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	lzwd_stream_checker u_decode_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_byte      (in_ch.in_byte),
		.stream_start (in_ch.stream_start),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_byte0    (out_ch.out_byte0),
		.out_byte1    (out_ch.out_byte1),
		.out_byte2    (out_ch.out_byte2),
		.out_byte3    (out_ch.out_byte3),
		.byte_count   (out_ch.byte_count),
		.run_end      (out_ch.run_end),
		.stream_end   (out_ch.stream_end),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg.ready),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.words_due    (words_due),
		.mismatches   (mismatches)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic push_byte(input data_t value, input bit start);
		while ($urandom_range(99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= value;
		in_ch.stream_start <= start;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// drain all pending output, then give a trailing flag or low byte time to finish
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (words_due != 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_regs(input bit mode, input logic [31:0] len);
		cfg.valid <= 1'b1;
		cfg.index <= REG_WINDOW_MODE;
		cfg.data <= 32'(mode);
		do @(posedge clk); while (!cfg.ready);
		cfg.index <= REG_OUTPUT_LENGTH;
		cfg.data <= len;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_mode = mode;
	endtask

	function automatic data_t pick_flags();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_run(input bit long_runs);
		int unsigned top;
		top = cur_mode ? LONG_MAXLEN : (long_runs ? SHORT_MAXLEN : 10);
		case ($urandom_range(7))
			0: return MIN_MATCH;
			1: return top;
			default: return $urandom_range(top, MIN_MATCH);
		endcase
	endfunction

	// well-formed token sequence that stops once stop_at bytes have been produced
	task automatic play_stream(input int unsigned stop_at, input int flip_after,
		input bit long_runs, input data_t first_flags);
		int unsigned made;
		int unsigned run;
		int          tokens;
		data_t       flags;
		addr_t       mask;
		addr_t       pos;
		addr_t       off;
		made = 0;
		tokens = 0;
		flags = first_flags;
		push_byte(flags, 1'b1);
		items++;
		while (made < stop_at) begin
			for (int i = 0; i < 8 && made < stop_at; i++) begin
				if (tokens == flip_after) begin
					settle();
					write_regs(~cur_mode, $urandom);
				end
				tokens++;
				mask = cur_mode ? LONG_MASK : SHORT_MASK;
				pos = ((cur_mode ? LONG_START : SHORT_START) + addr_t'(made)) & mask;
				if (flags[i]) begin
					push_byte(data_t'($urandom), 1'b0);
					made++;
					items++;
				end else begin
					run = pick_run(long_runs);
					// mostly recent history, often overlapping the copy itself
					case ($urandom_range(3))
						0, 1: off = (pos - addr_t'($urandom_range(24, 1))) & mask;
						2: off = (pos - addr_t'($urandom_range(made + 1, 1))) & mask;
						default: off = addr_t'($urandom) & mask;
					endcase
					push_byte(off[7:0], 1'b0);
					if (cur_mode)
						push_byte({off[11:8], 4'(run - MIN_MATCH)}, 1'b0);
					else
						push_byte({off[8], 7'(run - MIN_MATCH)}, 1'b0);
					made += run;
					items += 2;
				end
			end
			if (made < stop_at) begin
				flags = pick_flags();
				push_byte(flags, 1'b0);
				items++;
			end
		end
	endtask

	initial begin
		int          waited;
		int unsigned len;
		int unsigned stop;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= '0;
		in_ch.stream_start <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_WINDOW_MODE;
		cfg.data <= '0;
		gap_pct = 0;
		stall_pct = 0;
		items = 0;
		cur_mode = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle after reset: no stream yet, byte ignored
		push_byte(8'hA5, 1'b0);
		settle();
		write_regs(1'b1, 32'd0);
		// zero length stream stays idle
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		settle();
		write_regs(1'b1, 32'd1);
		play_stream(1, -1, 1'b0, 8'hFF);
		push_byte(8'h5A, 1'b0);
		settle();
		write_regs(1'b1, 32'd12);
		play_stream(12, -1, 1'b0, 8'h00);
		settle();
		write_regs(1'b0, 32'd150);
		play_stream(150, -1, 1'b1, 8'h80);
		// endless stream with a mode and length change part way, abandoned by the next start
		settle();
		write_regs(1'b1, 32'hFFFF_FFFF);
		play_stream(16, 3, 1'b0, 8'h55);

		while (items < 470) begin
			if (items < 157) begin
				gap_pct = 30;
				stall_pct = 47;
			end else if (items < 314) begin
				gap_pct = 47;
				stall_pct = 30;
			end else begin
				gap_pct = 0;
				stall_pct = 0;
			end
			case ($urandom_range(19))
				0: begin
					len = 0;
					stop = 0;
				end
				1, 2: begin
					len = $urandom_range(250, 20);
					stop = $urandom_range(len - 1, 1);
				end
				3, 4, 5: begin
					len = $urandom_range(300, 49);
					stop = len;
				end
				default: begin
					len = $urandom_range(48, 1);
					stop = len;
				end
			endcase
			settle();
			write_regs($urandom_range(1), len);
			play_stream(stop, -1, $urandom_range(3) == 0, pick_flags());
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(3, 1)) push_byte(data_t'($urandom), 1'b0);
		end

		in_ch.valid <= 1'b0;
		waited = 0;
		do begin
			@(negedge clk);
			waited++;
		end while (words_due != 0 && waited < 400000);
		repeat (40) @(negedge clk);
		if (words_due != 0)
			$error("%0d decoded requests never arrived", words_due);
		if (mismatches == 0 && words_due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
